>>> sv/apsp_pkg.sv
package apsp_pkg;

	// default sizes, handed down through the top level parameters
	localparam int MAX_VERTICES_DEF = 64;
	localparam int DIST_BITS_DEF    = 24;

	// fixed field widths of the item and result, and the vertex count width
	localparam int VERTEX_BITS   = 6;
	localparam int LEN_BITS      = 16;
	localparam int OUT_DIST_BITS = 24;
	localparam int COUNT_BITS    = 7;

	localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RST = 7'd64;

	typedef enum logic [1:0] {
		OP_WRITE_EDGE  = 2'd0,
		OP_CLEAR_EDGES = 2'd1,
		OP_COMPUTE     = 2'd2,
		OP_QUERY       = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [VERTEX_BITS-1:0] src_vertex;
		logic [VERTEX_BITS-1:0] dst_vertex;
		logic [LEN_BITS-1:0]    edge_length;
	} apsp_item_t;

	typedef struct packed {
		logic [OUT_DIST_BITS-1:0] distance;
		logic                     reachable;
		logic                     status;
	} apsp_result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic wipe;
		logic exec;
		logic clear;
		logic fill;
		logic row_rd;
		logic row_chk;
		logic col;
		logic finish;
	} apsp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic n_zero;
		logic dik_inf;
	} apsp_sts_t;

endpackage

>>> sv/apsp_ram.sv
module apsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/apsp_ctrl.sv
module apsp_ctrl #(
	parameter int VW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  apsp_pkg::apsp_sts_t    sts,
	input  logic [VW-1:0]          last_idx,
	output apsp_pkg::apsp_cmd_t    cmd,
	output logic [2*VW-1:0]        cnt,
	output logic [VW-1:0]          k_idx,
	output logic [VW-1:0]          i_idx,
	output logic [VW-1:0]          j_idx
);

	import apsp_pkg::*;

	localparam int AW = 2 * VW;

	typedef enum logic [8:0] {
		ST_WIPE    = 9'b0_0000_0001,
		ST_IDLE    = 9'b0_0000_0010,
		ST_EXEC    = 9'b0_0000_0100,
		ST_CLEAR   = 9'b0_0000_1000,
		ST_FILL    = 9'b0_0001_0000,
		ST_ROW_RD  = 9'b0_0010_0000,
		ST_ROW_CHK = 9'b0_0100_0000,
		ST_COL     = 9'b0_1000_0000,
		ST_DONE    = 9'b1_0000_0000
	} state_t;

	state_t         st_q, st_d;
	logic [AW-1:0]  cnt_q;
	logic [VW-1:0]  k_q, i_q, j_q;
	logic           accept;
	logic           adv_row;
	logic           last_row;

	assign busy     = !(st_q == ST_IDLE || st_q == ST_DONE);
	assign accept   = start && !busy;
	assign last_row = (i_q == last_idx) && (k_q == last_idx);
	assign adv_row  = (st_q == ST_ROW_CHK && sts.dik_inf) ||
	                  (st_q == ST_COL && j_q == last_idx);

	assign cnt   = cnt_q;
	assign k_idx = k_q;
	assign i_idx = i_q;
	assign j_idx = j_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		st_d       = st_q;
		unique case (st_q)
			ST_WIPE: begin
				cmd.wipe = 1'b1;
				if (&cnt_q) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) st_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				unique case (sts.op)
					OP_CLEAR_EDGES: st_d = ST_CLEAR;
					OP_COMPUTE:     st_d = ST_FILL;
					OP_WRITE_EDGE:  st_d = ST_DONE;
					OP_QUERY:       st_d = ST_DONE;
					default:        st_d = ST_DONE;
				endcase
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (&cnt_q) st_d = ST_DONE;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (&cnt_q) st_d = sts.n_zero ? ST_DONE : ST_ROW_RD;
			end
			ST_ROW_RD: begin
				cmd.row_rd = 1'b1;
				st_d       = ST_ROW_CHK;
			end
			ST_ROW_CHK: begin
				cmd.row_chk = 1'b1;
				if (sts.dik_inf) st_d = last_row ? ST_DONE : ST_ROW_RD;
				else st_d = ST_COL;
			end
			ST_COL: begin
				cmd.col = 1'b1;
				if (j_q == last_idx) st_d = last_row ? ST_DONE : ST_ROW_RD;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				st_d       = accept ? ST_EXEC : ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_WIPE;
			cnt_q <= '0;
			k_q   <= '0;
			i_q   <= '0;
			j_q   <= '0;
		end else begin
			st_q <= st_d;
			// sweep counter wraps back to zero at the end of each pass
			if (st_q == ST_WIPE || st_q == ST_CLEAR || st_q == ST_FILL) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (st_q == ST_FILL) begin
				k_q <= '0;
				i_q <= '0;
				j_q <= '0;
			end else if (adv_row) begin
				j_q <= '0;
				if (i_q == last_idx) begin
					i_q <= '0;
					k_q <= k_q + VW'(1);
				end else begin
					i_q <= i_q + VW'(1);
				end
			end else if (st_q == ST_COL) begin
				j_q <= j_q + VW'(1);
			end
		end
	end

	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXEC) |-> $past(start && !busy))
		else $error("command executed without an accepted start");

	a_loop_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COL) |-> (j_q <= last_idx && i_q <= last_idx && k_q <= last_idx))
		else $error("relaxation index beyond vertex count");

endmodule

>>> sv/apsp_dpath.sv
module apsp_dpath #(
	parameter int MAX_VERTICES = 64,
	parameter int DIST_BITS    = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  apsp_pkg::apsp_item_t                item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [apsp_pkg::COUNT_BITS-1:0]     cfg_data,
	input  apsp_pkg::apsp_cmd_t                 cmd,
	input  logic [2*$clog2(MAX_VERTICES)-1:0]   cnt,
	input  logic [$clog2(MAX_VERTICES)-1:0]     k_idx,
	input  logic [$clog2(MAX_VERTICES)-1:0]     i_idx,
	input  logic [$clog2(MAX_VERTICES)-1:0]     j_idx,
	output apsp_pkg::apsp_sts_t                 sts,
	output logic [$clog2(MAX_VERTICES)-1:0]     last_idx,
	output apsp_pkg::apsp_result_t              result,
	output logic                                done
);

	import apsp_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int CW    = (NW > COUNT_BITS) ? NW : COUNT_BITS;
	localparam int RW    = (NW > VERTEX_BITS) ? NW : VERTEX_BITS;
	localparam int EW    = LEN_BITS + 1;
	localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

	logic [COUNT_BITS-1:0] vcount_q;
	apsp_item_t            item_q;
	logic [DIST_BITS-1:0]  dik_q;
	logic                  fill_s1, relax_s1;
	logic [AW-1:0]         waddr_s1;
	apsp_result_t          result_q, res_d;
	logic                  done_q;

	logic [CW-1:0]        vc_ext, n_w;
	logic [NW-1:0]        n_act, n_m1;
	logic [RW-1:0]        src_ext, dst_ext;
	logic [VW-1:0]        src_idx, dst_idx;
	logic                 in_range;

	logic                 e_we;
	logic [AW-1:0]        e_waddr;
	logic [EW-1:0]        e_wdata, e_rdata;
	logic                 d_we;
	logic [AW-1:0]        d_waddr, a_raddr;
	logic [DIST_BITS-1:0] d_wdata, a_rdata, b_rdata;

	logic [VW-1:0]        fa, fb;
	logic [DIST_BITS-1:0] fill_val, init_val, sat;
	logic [DIST_BITS:0]   sum;
	logic                 upd;

	// active vertex count, clipped to the store size
	assign vc_ext   = CW'(vcount_q);
	assign n_w      = (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;
	assign n_act    = n_w[NW-1:0];
	assign n_m1     = n_act - NW'(1);
	assign last_idx = n_m1[VW-1:0];

	assign src_ext  = RW'(item_q.src_vertex);
	assign dst_ext  = RW'(item_q.dst_vertex);
	assign src_idx  = src_ext[VW-1:0];
	assign dst_idx  = dst_ext[VW-1:0];
	assign in_range = (src_ext < RW'(n_act)) && (dst_ext < RW'(n_act));

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VERTEX_COUNT_RST;
			fill_s1  <= 1'b0;
			relax_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			fill_s1  <= cmd.fill;
			relax_s1 <= cmd.col;
			done_q   <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
		if (cmd.row_chk) dik_q <= a_rdata;
		waddr_s1 <= cmd.fill ? cnt : {i_idx, j_idx};
		if (cmd.finish) result_q <= res_d;
	end

	assign sts.op      = item_q.op;
	assign sts.n_zero  = (n_act == '0);
	assign sts.dik_inf = (a_rdata == DIST_INF);

	// edge store: single writes, cleared by sweep
	assign e_we    = cmd.wipe || cmd.clear ||
	                 (cmd.exec && item_q.op == OP_WRITE_EDGE && in_range);
	assign e_waddr = (cmd.wipe || cmd.clear) ? cnt : {src_idx, dst_idx};
	assign e_wdata = (cmd.wipe || cmd.clear) ? '0 : {1'b1, item_q.edge_length};

	apsp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (cnt),
		.rdata (e_rdata)
	);

	// fill value from the edge read in the previous cycle
	assign fa = waddr_s1[AW-1:VW];
	assign fb = waddr_s1[VW-1:0];
	always_comb begin
		if (fa == fb) fill_val = '0;
		else if (NW'(fa) < n_act && NW'(fb) < n_act && e_rdata[LEN_BITS])
			fill_val = DIST_BITS'(e_rdata[LEN_BITS-1:0]);
		else fill_val = DIST_INF;
	end

	assign init_val = (cnt[AW-1:VW] == cnt[VW-1:0]) ? '0 : DIST_INF;

	// relaxation: a holds d[k][j], b holds d[i][j]
	assign sum = {1'b0, dik_q} + {1'b0, a_rdata};
	assign sat = (sum >= {1'b0, DIST_INF}) ? (DIST_INF - DIST_BITS'(1)) : sum[DIST_BITS-1:0];
	assign upd = (a_rdata != DIST_INF) && (sat < b_rdata);

	assign d_we    = cmd.wipe || fill_s1 || (relax_s1 && upd);
	assign d_waddr = cmd.wipe ? cnt : waddr_s1;
	always_comb begin
		priority if (cmd.wipe) d_wdata = init_val;
		else if (fill_s1) d_wdata = fill_val;
		else d_wdata = sat;
	end

	always_comb begin
		priority if (cmd.exec) a_raddr = {src_idx, dst_idx};
		else if (cmd.row_rd) a_raddr = {i_idx, k_idx};
		else a_raddr = {k_idx, j_idx};
	end

	// two copies of the distance store, written alike, one read port each
	apsp_ram #(.WIDTH(DIST_BITS), .DEPTH(DEPTH)) u_dist_a (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	apsp_ram #(.WIDTH(DIST_BITS), .DEPTH(DEPTH)) u_dist_b (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr ({i_idx, j_idx}),
		.rdata (b_rdata)
	);

	always_comb begin
		res_d = '0;
		if ((item_q.op == OP_WRITE_EDGE || item_q.op == OP_QUERY) && !in_range) begin
			res_d.status = 1'b1;
		end else if (item_q.op == OP_QUERY) begin
			res_d.distance  = OUT_DIST_BITS'(a_rdata);
			res_d.reachable = (a_rdata != DIST_INF);
		end
	end

	assign result = result_q;
	assign done   = done_q;

	a_reach_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.reachable) |-> !result_q.status)
		else $error("reachable result flagged as ignored");

	a_no_diag_relax: assert property (@(posedge clk) disable iff (!arst_n)
		(relax_s1 && upd) |-> (waddr_s1[AW-1:VW] != waddr_s1[VW-1:0]))
		else $error("relaxation wrote a diagonal entry");

endmodule

>>> sv/all_pairs_shortest_path_core.sv
// edge write, query: the result strobe follows the EXEC and DONE states once start is taken;
// a new command can be taken in DONE; clear edges: a sweep over all store entries, one a cycle
// compute: that sweep again, then, unless no vertex is in use, per (k, i) the ROW_RD and
//   ROW_CHK states, plus a walk over every column j for each finite d[i][k]
// reset: busy stays high for a clearing pass over every entry of the edge and distance stores
// results are shown for one cycle on done; the receiver cannot stall
module all_pairs_shortest_path_core #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF,
	parameter int DIST_BITS    = apsp_pkg::DIST_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side: taken when start is high and busy is low
	input  logic                            start,
	output logic                            busy,
	input  apsp_pkg::apsp_item_t            item,
	// vertex count register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [apsp_pkg::COUNT_BITS-1:0] cfg_data,
	// result side: one transfer per command, marked by done
	output logic                            done,
	output apsp_pkg::apsp_result_t          result
);

	import apsp_pkg::*;

	// vertex index width; store addresses are {row, column}
	localparam int VW = $clog2(MAX_VERTICES);

	apsp_cmd_t     cmd;
	apsp_sts_t     sts;
	logic [2*VW-1:0] cnt;
	logic [VW-1:0] k_idx, i_idx, j_idx;
	logic [VW-1:0] last_idx;

	// sequencer: reset wipe, sweeps for clear and fill, and the k, i, j
	// relaxation walk with one relaxation per cycle along a row
	apsp_ctrl #(.VW(VW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sts      (sts),
		.last_idx (last_idx),
		.cmd      (cmd),
		.cnt      (cnt),
		.k_idx    (k_idx),
		.i_idx    (i_idx),
		.j_idx    (j_idx)
	);

	// stores, the vertex count register, saturating add and compare,
	// and the result register
	apsp_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.DIST_BITS    (DIST_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.cnt       (cnt),
		.k_idx     (k_idx),
		.i_idx     (i_idx),
		.j_idx     (j_idx),
		.sts       (sts),
		.last_idx  (last_idx),
		.result    (result),
		.done      (done)
	);

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

// testbench for the all-pairs shortest path core
// a negedge driver feeds commands from a queue; a posedge monitor predicts every
// accepted command against a shadow copy of the edge and distance stores and checks
// each result transfer in order
module tb_top;
	import apsp_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam logic [OUT_DIST_BITS-1:0] DIST_INF = '1;
	localparam int CLK_PERIOD = 10;
	localparam longint TIMEOUT_CYCLES = 8_000_000;
	localparam int MAX_REPORTS = 10;

	// one expected answer, kept with the command that caused it for reporting
	typedef struct packed {
		apsp_item_t   cmd;
		apsp_result_t ans;
	} answer_due_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	apsp_item_t            item = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_BITS-1:0] cfg_data = '0;
	logic                  done;
	apsp_result_t          result;

	// shadow state of the block
	bit        edge_set [NV][NV];
	bit [15:0] edge_len [NV][NV];
	bit [23:0] shadow_dist [NV][NV];
	bit [6:0]  shadow_vcount;

	apsp_item_t  cmds_pending [$];
	answer_due_t answers_due [$];

	logic took_cmd = 1'b0;
	int   sender_idle_pct = 19;
	int   queued_cmds = 0;
	int   results_checked = 0;
	int   mismatch_count = 0;
	int   cfg_writes = 0;
	int   op_seen [4] = '{0, 0, 0, 0};

	// random phases: vertex count, sender idle percentage, commands
	int seg_vcount [7] = '{8, 3, 12, 5, 16, 2, 12};
	int seg_idle   [7] = '{19, 19, 83, 83, 0, 0, 0};
	int seg_items  [7] = '{220, 160, 220, 160, 150, 150, 150};

	all_pairs_shortest_path_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// shadow model
	// ------------------------------------------------------------------

	// counts above the array size behave as the array size
	function automatic int vertices_in_use();
		return (shadow_vcount > NV) ? NV : int'(shadow_vcount);
	endfunction

	// diagonal zero, everything else unreachable
	function automatic void fill_distance_base();
		foreach (shadow_dist[a, b])
			shadow_dist[a][b] = (a == b) ? 24'd0 : DIST_INF;
	endfunction

	// rebuild from the edges, then relax in place in k, i, j order;
	// only finite terms are added and sums stop one below infinite
	function automatic void rebuild_shadow_distances();
		int        n;
		bit [23:0] dik;
		bit [24:0] sum;
		n = vertices_in_use();
		fill_distance_base();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (i != j && edge_set[i][j])
					shadow_dist[i][j] = 24'(edge_len[i][j]);
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				dik = shadow_dist[i][k];
				if (dik == DIST_INF)
					continue;
				for (int j = 0; j < n; j++) begin
					if (shadow_dist[k][j] == DIST_INF)
						continue;
					sum = {1'b0, dik} + {1'b0, shadow_dist[k][j]};
					if (sum >= {1'b0, DIST_INF})
						sum = {1'b0, DIST_INF - 24'd1};
					if (sum < {1'b0, shadow_dist[i][j]})
						shadow_dist[i][j] = sum[23:0];
				end
			end
		end
	endfunction

	// applies one command to the shadow state and returns its answer
	function automatic apsp_result_t predict_graph_answer(apsp_item_t c);
		apsp_result_t r;
		int           n;
		bit           in_range;
		r = '0;
		n = vertices_in_use();
		in_range = (int'(c.src_vertex) < n) && (int'(c.dst_vertex) < n);
		case (c.op)
			OP_WRITE_EDGE: begin
				if (in_range) begin
					edge_set[c.src_vertex][c.dst_vertex] = 1'b1;
					edge_len[c.src_vertex][c.dst_vertex] = c.edge_length;
				end else begin
					r.status = 1'b1;
				end
			end
			OP_CLEAR_EDGES: begin
				foreach (edge_set[a, b])
					edge_set[a][b] = 1'b0;
			end
			OP_COMPUTE: begin
				rebuild_shadow_distances();
			end
			OP_QUERY: begin
				if (in_range) begin
					r.distance  = shadow_dist[c.src_vertex][c.dst_vertex];
					r.reachable = (r.distance != DIST_INF);
				end else begin
					r.status = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// driver: one command transfer at a time, gaps drawn per cycle
	// ------------------------------------------------------------------

	// took_cmd tells whether the command on the port went at the last rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took_cmd) begin
			if (cmds_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				item <= cmds_pending.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predicts at each command transfer, checks each result transfer
	// ------------------------------------------------------------------

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : monitor
		answer_due_t due;
		string       msg_exp;
		string       msg_got;
		took_cmd <= arst_n && start && !busy;
		// results first: a result never belongs to the command taken at the same edge
		if (arst_n && done === 1'b1) begin
			if (answers_due.size() == 0) begin
				log_mismatch($sformatf(
					"result with nothing pending: distance=%0d reachable=%0b status=%0b",
					result.distance, result.reachable, result.status));
			end else begin
				due = answers_due.pop_front();
				results_checked++;
				if (result.distance !== due.ans.distance ||
						result.reachable !== due.ans.reachable ||
						result.status !== due.ans.status) begin
					msg_exp = $sformatf(
						"%s src %0d dst %0d: expected distance=%0d reachable=%0b status=%0b",
						due.cmd.op.name(), due.cmd.src_vertex, due.cmd.dst_vertex,
						due.ans.distance, due.ans.reachable, due.ans.status);
					msg_got = $sformatf(", got distance=%0d reachable=%0b status=%0b",
						result.distance, result.reachable, result.status);
					log_mismatch({msg_exp, msg_got});
				end
			end
		end
		if (arst_n && start && !busy) begin
			op_seen[item.op]++;
			due.cmd = item;
			due.ans = predict_graph_answer(item);
			answers_due.insert(answers_due.size(), due);
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	task automatic queue_cmd(input op_t op, input int src, input int dst, input int len);
		apsp_item_t c;
		c.op          = op;
		c.src_vertex  = VERTEX_BITS'(src);
		c.dst_vertex  = VERTEX_BITS'(dst);
		c.edge_length = LEN_BITS'(len);
		cmds_pending.insert(cmds_pending.size(), c);
		queued_cmds++;
	endtask

	// mostly vertices in use, sometimes any vertex number
	function automatic int pick_vertex();
		int n;
		n = vertices_in_use();
		if (n > 0 && $urandom_range(99) < 88)
			return $urandom_range(n - 1);
		return $urandom_range(NV - 1);
	endfunction

	function automatic int pick_length();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'hFFFF;
			2, 3, 4: return $urandom_range(100, 1);
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	// a rare clear, edges with a few stale queries mixed in, usually a rebuild,
	// then queries with a few late edge writes
	task automatic queue_graph_batch();
		int writes;
		int reads;
		writes = $urandom_range(14, 2);
		reads  = $urandom_range(12, 3);
		if ($urandom_range(9) == 0)
			queue_cmd(OP_CLEAR_EDGES, $urandom_range(63), $urandom_range(63), $urandom);
		repeat (writes) begin
			if ($urandom_range(9) < 8)
				queue_cmd(OP_WRITE_EDGE, pick_vertex(), pick_vertex(), pick_length());
			else
				queue_cmd(OP_QUERY, pick_vertex(), pick_vertex(), $urandom);
		end
		if ($urandom_range(4) != 0)
			queue_cmd(OP_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom);
		repeat (reads) begin
			if ($urandom_range(9) < 8)
				queue_cmd(OP_QUERY, pick_vertex(), pick_vertex(), $urandom);
			else
				queue_cmd(OP_WRITE_EDGE, pick_vertex(), pick_vertex(), pick_length());
		end
	endtask

	// nothing queued, nothing on the port, nothing outstanding
	task automatic wait_for_quiet();
		while (cmds_pending.size() != 0 || start || answers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register transfer; only issued while the block is quiet
	task automatic write_vertex_count(input logic [COUNT_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_vcount = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int target;
		fill_distance_base();
		shadow_vcount = VERTEX_COUNT_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// reset contents, edge extremes, self edge, replaced edge, stale read,
		// one full-size rebuild, a vertex with no outgoing edge, clear keeps distances
		queue_cmd(OP_QUERY, 0, 0, 0);
		queue_cmd(OP_QUERY, 0, 63, 16'hFFFF);
		queue_cmd(OP_WRITE_EDGE, 0, 1, 0);
		queue_cmd(OP_WRITE_EDGE, 1, 63, 16'hFFFF);
		queue_cmd(OP_WRITE_EDGE, 63, 0, 12345);
		queue_cmd(OP_WRITE_EDGE, 5, 5, 7);
		queue_cmd(OP_WRITE_EDGE, 0, 1, 3);
		queue_cmd(OP_QUERY, 0, 1, 0);
		queue_cmd(OP_COMPUTE, 63, 63, 16'hFFFF);
		queue_cmd(OP_QUERY, 0, 1, 0);
		queue_cmd(OP_QUERY, 0, 63, 0);
		queue_cmd(OP_QUERY, 63, 1, 0);
		queue_cmd(OP_QUERY, 5, 5, 0);
		queue_cmd(OP_QUERY, 7, 9, 0);
		queue_cmd(OP_CLEAR_EDGES, 0, 0, 0);
		queue_cmd(OP_QUERY, 0, 1, 0);

		// no vertex in use: writes and queries refused, rebuild leaves only the diagonal
		wait_for_quiet();
		write_vertex_count(7'd0);
		queue_cmd(OP_WRITE_EDGE, 0, 0, 1);
		queue_cmd(OP_QUERY, 0, 0, 0);
		queue_cmd(OP_COMPUTE, 0, 0, 0);
		queue_cmd(OP_CLEAR_EDGES, 63, 63, 16'hFFFF);

		// count above the array size acts as the full array
		wait_for_quiet();
		write_vertex_count(7'd127);
		queue_cmd(OP_WRITE_EDGE, 62, 63, 40);
		queue_cmd(OP_QUERY, 63, 63, 0);

		// single vertex
		wait_for_quiet();
		write_vertex_count(7'd1);
		queue_cmd(OP_WRITE_EDGE, 0, 0, 9);
		queue_cmd(OP_WRITE_EDGE, 0, 1, 5);
		queue_cmd(OP_COMPUTE, 0, 0, 0);
		queue_cmd(OP_QUERY, 0, 0, 0);
		queue_cmd(OP_QUERY, 1, 0, 0);

		wait_for_quiet();
		write_vertex_count(7'd64);
		queue_cmd(OP_QUERY, 62, 63, 0);

		// random graphs at small sizes so rebuilds stay short; edges left from
		// larger phases stay stored but fall outside the smaller ones
		foreach (seg_vcount[s]) begin
			wait_for_quiet();
			sender_idle_pct = seg_idle[s];
			write_vertex_count(seg_vcount[s][COUNT_BITS-1:0]);
			target = queued_cmds + seg_items[s];
			while (queued_cmds < target)
				queue_graph_batch();
		end

		wait_for_quiet();
		repeat (16) @(posedge clk);
		$display(
			"checked %0d results of %0d commands: %0d writes, %0d queries, %0d clears, %0d rebuilds",
			results_checked, queued_cmds, op_seen[OP_WRITE_EDGE], op_seen[OP_QUERY],
			op_seen[OP_CLEAR_EDGES], op_seen[OP_COMPUTE]);
		$display("%0d vertex count writes, sender gaps at 19, 83 and 0 percent, %0d mismatches",
			cfg_writes, mismatch_count);
		if (mismatch_count == 0 && answers_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Regression FAIL");
		$finish;
	end

endmodule
